FILE: src/ttt_pkg.sv
// ----------------------------------------------------------------------------
// ttt_pkg: shared types and constants
// Beat formats, action codes and table geometry of the two-way table.
// ----------------------------------------------------------------------------
package ttt_pkg;

   localparam int BUCKET_COUNT = 1024;
   localparam int IDX_W = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
   localparam int ENTRY_W = 128;
   localparam int TAG_W = 6;
   localparam int AGE_WEIGHT = 1000;
   localparam int EXACT_PENALTY = 5000;
   localparam int VICTIM_FLOOR = -10000;
   localparam int SCORE_W = 18;
   localparam logic [1:0] BOUND_EXACT = 2'd1;

   typedef enum logic [1:0] {
      ACT_PROBE  = 2'd0,
      ACT_STORE  = 2'd1,
      ACT_SEARCH = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [63:0]        key;
      logic [15:0]        best_move;
      logic signed [15:0] search_score;
      logic signed [15:0] static_eval;
      logic [7:0]         search_depth;
      logic [1:0]         bound_kind;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [15:0]        out_move;
      logic signed [15:0] out_score;
      logic signed [15:0] out_eval;
      logic [7:0]         out_depth;
      logic [1:0]         out_bound;
      logic [5:0]         out_age_tag;
   } rsp_type;

   // 64+16+16+16+8+2+6 = 128
   typedef struct packed {
      logic [63:0] key;
      logic [15:0] move;
      logic [15:0] score;
      logic [15:0] eval;
      logic [7:0]  depth;
      logic [1:0]  bound;
      logic [5:0]  tag;
   } entry_type;

   // front-to-back queue item
   typedef struct packed {
      req_type          req;
      logic [IDX_W-1:0] idx;
   } cmd_type;

   function automatic logic [IDX_W-1:0] bucket_of(input logic [63:0] key);
      logic [63:0] m;
      m = 64'(BUCKET_COUNT - 1);
      return IDX_W'(key & m);
   endfunction

endpackage

FILE: src/ttt_ram.sv
// ----------------------------------------------------------------------------
// ttt_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module ttt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end
endmodule

FILE: src/ttt_front.sv
// ----------------------------------------------------------------------------
// ttt_front: request intake
// Accepts command beats, computes the bucket index, queues for the back end.
// ----------------------------------------------------------------------------
module ttt_front
   import ttt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    q_valid,
   output cmd_type q_data,
   input  logic    q_pop
);
   cmd_type     buf_ff [2];
   logic        wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push;

   assign busy    = (cnt_ff == 2'd2);
   assign push    = start && !busy;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_data  = buf_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = q_pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         buf_ff[wp_ff] <= '{req: req_data, idx: bucket_of(req_data.key)};
      end
   end
endmodule

FILE: src/ttt_back.sv
// ----------------------------------------------------------------------------
// ttt_back: bucket engine
// Clears the table after reset, then runs read-decide-write per command.
// ----------------------------------------------------------------------------
module ttt_back
   import ttt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  cmd_type q_data,
   output logic    q_pop,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);
   typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_DECIDE} state_type;

   state_type         state_ff;
   logic [IDX_W-1:0]  clr_ff;
   logic [7:0]        gen_ff;
   logic              strobe_ff;
   rsp_type           rsp_ff;
   cmd_type           cmd_ff;

   logic [IDX_W-1:0]  addr;
   entry_type         w0_wd, w1_wd, w0_rd, w1_rd;
   logic              we0, we1;

   ttt_ram #(.WIDTH(ENTRY_W), .DEPTH(BUCKET_COUNT)) u_way0 (
      .clock(clock), .we(we0), .addr(addr), .wdata(w0_wd), .rdata(w0_rd));
   ttt_ram #(.WIDTH(ENTRY_W), .DEPTH(BUCKET_COUNT)) u_way1 (
      .clock(clock), .we(we1), .addr(addr), .wdata(w1_wd), .rdata(w1_rd));

   logic [5:0]  tag;
   logic        m0, m1, hitw;
   entry_type   e, ne;
   logic [5:0]  a0, a1;
   logic signed [SCORE_W-1:0] v0, v1;
   logic        pick1, take;

   assign tag   = gen_ff[5:0];
   assign q_pop = (state_ff == S_IDLE) && q_valid;
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      m0   = (w0_rd.key == cmd_ff.req.key);
      m1   = (w1_rd.key == cmd_ff.req.key);
      hitw = !m0;
      e    = m0 ? w0_rd : w1_rd;
      a0   = tag - w0_rd.tag;
      a1   = tag - w1_rd.tag;
      v0 = SCORE_W'(a0) * SCORE_W'(AGE_WEIGHT) - SCORE_W'(w0_rd.depth)
           - ((w0_rd.bound == BOUND_EXACT) ? SCORE_W'(EXACT_PENALTY) : '0);
      v1 = SCORE_W'(a1) * SCORE_W'(AGE_WEIGHT) - SCORE_W'(w1_rd.depth)
           - ((w1_rd.bound == BOUND_EXACT) ? SCORE_W'(EXACT_PENALTY) : '0);
      // way 0 always beats the floor (min score is -5255)
      pick1 = (v1 > v0) && (v0 > SCORE_W'(VICTIM_FLOOR)) || (v1 > v0);
      take  = (cmd_ff.req.search_depth >= e.depth) || (e.tag != tag);
      ne = '{key: cmd_ff.req.key, move: cmd_ff.req.best_move,
             score: cmd_ff.req.search_score, eval: cmd_ff.req.static_eval,
             depth: cmd_ff.req.search_depth, bound: cmd_ff.req.bound_kind,
             tag: tag};
      we0 = 1'b0; we1 = 1'b0;
      w0_wd = '0; w1_wd = '0;
      addr = cmd_ff.idx;
      case (state_ff)
         S_CLEAR: begin
            addr = clr_ff;
            we0 = 1'b1; we1 = 1'b1;
         end
         S_IDLE: addr = q_data.idx;
         S_DECIDE: begin
            w0_wd = w0_rd;
            w1_wd = w1_rd;
            case (action_type'(cmd_ff.req.action))
               ACT_PROBE: begin
                  if (m0) begin
                     we0 = 1'b1; w0_wd.tag = tag;
                  end else if (m1) begin
                     we1 = 1'b1; w1_wd.tag = tag;
                  end
               end
               ACT_STORE: begin
                  if (m0 || m1) begin
                     if (hitw) begin
                        we1 = 1'b1; w1_wd = take ? ne : w1_rd; w1_wd.tag = tag;
                     end else begin
                        we0 = 1'b1; w0_wd = take ? ne : w0_rd; w0_wd.tag = tag;
                     end
                  end else if (pick1) begin
                     we1 = 1'b1; w1_wd = ne;
                  end else begin
                     we0 = 1'b1; w0_wd = ne;
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         gen_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= (state_ff == S_DECIDE);
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + IDX_W'(1);
               if (clr_ff == IDX_W'(BUCKET_COUNT - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (q_valid) begin
                  cmd_ff   <= q_data;
                  state_ff <= S_READ;
               end
            end
            S_READ: state_ff <= S_DECIDE;
            S_DECIDE: begin
               state_ff  <= S_IDLE;
               if (action_type'(cmd_ff.req.action) == ACT_PROBE && (m0 || m1)) begin
                  rsp_ff <= '{hit: 1'b1, out_move: e.move, out_score: e.score,
                              out_eval: e.eval, out_depth: e.depth,
                              out_bound: e.bound, out_age_tag: e.tag};
               end else begin
                  rsp_ff <= '0;
               end
               if (action_type'(cmd_ff.req.action) == ACT_SEARCH) begin
                  gen_ff <= gen_ff + 8'd1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

FILE: src/two_way_transposition_table_top.sv
// ----------------------------------------------------------------------------
// two_way_transposition_table_top: two-way hashed position table
// Probe, store and new-search commands on a 1024-bucket, two-way table.
// ----------------------------------------------------------------------------
// Usage:
//   Command beats enter on req_data when start is high and busy is low.
//   Every command yields exactly one response beat on rsp_data, marked by
//   rsp_strobe for one cycle; the receiver cannot stall it.
//   A two-entry queue decouples intake from the bucket engine.
//   An accepted command waits in the queue until the engine is idle, then
//   passes through S_READ and S_DECIDE; rsp_strobe is registered from S_DECIDE.
//   The engine works on one command at a time through its dispatch, read and
//   decide/write steps on the single RAM port per way; new commands wait meanwhile.
//   Reset: the engine clears both way RAMs, one bucket per cycle, over all
//   BUCKET_COUNT (1024) buckets; commands queue meanwhile and busy rises
//   once the queue is full. The generation counter resets to zero.
//   Responses come out in command order.
// ----------------------------------------------------------------------------
module two_way_transposition_table_top
   import ttt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);
   logic    q_valid, q_pop;
   cmd_type q_data;

   ttt_front u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop));

   ttt_back u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_data(q_data),
      .q_pop(q_pop), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data));
endmodule

FILE: tb/two_way_transposition_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_way_transposition_table_checker: response predictor and comparator
// Watches accepted command beats, keeps its own copy of the two-way table
// and generation counter, and compares every response beat with the predicted one.
// ----------------------------------------------------------------------------
module two_way_transposition_table_checker
   import ttt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_strobe,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count
);

   entry_type table_way0 [BUCKET_COUNT];
   entry_type table_way1 [BUCKET_COUNT];
   logic [7:0] gen_count;
   rsp_type    expected_rsp [$];

   function automatic int evict_rank(entry_type e, logic [5:0] cur_tag);
      int age;
      int v;
      age = int'(6'(cur_tag - e.tag));
      v = age * AGE_WEIGHT - int'(e.depth);
      if (e.bound == BOUND_EXACT) v -= EXACT_PENALTY;
      return v;
   endfunction

   function automatic entry_type fill_entry(req_type r, logic [5:0] cur_tag);
      entry_type e;
      e.key = r.key;
      e.move = r.best_move;
      e.score = r.search_score;
      e.eval = r.static_eval;
      e.depth = r.search_depth;
      e.bound = r.bound_kind;
      e.tag = cur_tag;
      return e;
   endfunction

   task automatic apply_command(req_type r);
      rsp_type    res;
      entry_type  e [2];
      logic [5:0] cur_tag;
      int         idx;
      int         found;
      int         best;
      int         pick;
      int         v;
      res = '0;
      cur_tag = gen_count[5:0];
      idx = int'(r.key & 64'(BUCKET_COUNT - 1));
      e[0] = table_way0[idx];
      e[1] = table_way1[idx];
      found = -1;
      for (int w = 0; w < 2; w++)
         if (found < 0 && e[w].key == r.key) found = w;
      case (action_type'(r.action))
         ACT_PROBE: begin
            if (found >= 0) begin
               res.hit = 1'b1;
               res.out_move = e[found].move;
               res.out_score = e[found].score;
               res.out_eval = e[found].eval;
               res.out_depth = e[found].depth;
               res.out_bound = e[found].bound;
               res.out_age_tag = e[found].tag;
               e[found].tag = cur_tag;
            end
         end
         ACT_STORE: begin
            if (found >= 0) begin
               if (r.search_depth >= e[found].depth || e[found].tag != cur_tag)
                  e[found] = fill_entry(r, cur_tag);
               else
                  e[found].tag = cur_tag;
            end else begin
               best = VICTIM_FLOOR;
               pick = 0;
               for (int w = 0; w < 2; w++) begin
                  v = evict_rank(e[w], cur_tag);
                  if (v > best) begin
                     best = v;
                     pick = w;
                  end
               end
               e[pick] = fill_entry(r, cur_tag);
            end
         end
         ACT_SEARCH: gen_count = gen_count + 8'd1;
         default: ;
      endcase
      table_way0[idx] = e[0];
      table_way1[idx] = e[1];
      expected_rsp.push_back(res);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < BUCKET_COUNT; i++) begin
            table_way0[i] = '0;
            table_way1[i] = '0;
         end
         gen_count = '0;
         expected_rsp.delete();
         fail_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_rsp.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected response beat %p", rsp_data);
            end else begin
               want = expected_rsp.pop_front();
               if (want !== rsp_data) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("response mismatch: expected %p got %p", want, rsp_data);
               end
            end
         end
         if (start && !busy) apply_command(req_data);
      end
      pending_count = expected_rsp.size();
   end

endmodule

FILE: tb/two_way_transposition_table_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_way_transposition_table_top_tb: testbench top
// Drives directed and random probe/store/new-search/no-op beats, with random gaps
// in part of the random run, checks responses through the checker and prints the verdict.
// ----------------------------------------------------------------------------
module two_way_transposition_table_top_tb;
   import ttt_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   int      cycle_count;
   logic [63:0] key_pool [16];

   two_way_transposition_table_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   two_way_transposition_table_checker checker_inst (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // one command beat; gaps only where idling is on, start stays high after
   task automatic send_beat(req_type r, bit allow_gap);
      if (allow_gap)
         while ($urandom_range(99) < 15) begin
            start <= 1'b0;
            @(negedge clock);
         end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic req_type make_req(action_type a, logic [63:0] k, logic [7:0] d,
                                        logic [1:0] b);
      req_type r;
      r.action = a;
      r.key = k;
      r.best_move = 16'($urandom);
      r.search_score = 16'($urandom);
      r.static_eval = 16'($urandom);
      r.search_depth = d;
      r.bound_kind = b;
      return r;
   endfunction

   function automatic req_type random_req();
      req_type    r;
      int         sel;
      logic [63:0] k;
      sel = $urandom_range(99);
      if ($urandom_range(9) < 8) k = key_pool[$urandom_range(15)];
      else k = {$urandom, $urandom};
      r = make_req(ACT_STORE, k, 8'($urandom_range(255)), 2'($urandom));
      if (sel < 40) r.action = ACT_PROBE;
      else if (sel < 85) r.action = ACT_STORE;
      else if (sel < 97) r.action = ACT_SEARCH;
      else r.action = ACT_NONE;
      return r;
   endfunction

   initial begin
      req_type r;
      start = 1'b0;
      req_data = '0;
      reset = 1'b1;
      // keys sharing few buckets so both ways and evictions get exercised
      for (int i = 0; i < 16; i++)
         key_pool[i] = {$urandom, $urandom} & ~64'(BUCKET_COUNT - 1)
                       | 64'($urandom_range(3));
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed
      send_beat(make_req(ACT_PROBE, 64'd0, 8'd0, 2'd0), 0);
      send_beat(make_req(ACT_STORE, 64'd0, 8'd0, 2'd0), 0);
      send_beat(make_req(ACT_PROBE, '1, 8'd0, 2'd0), 0);
      send_beat(make_req(ACT_STORE, '1, 8'd255, BOUND_EXACT), 0);
      send_beat(make_req(ACT_PROBE, '1, 8'd0, 2'd0), 0);
      send_beat(make_req(ACT_STORE, '1, 8'd3, 2'd2), 0);
      send_beat(make_req(ACT_STORE, 64'h400, 8'd10, 2'd3), 0);
      send_beat(make_req(ACT_STORE, 64'h800, 8'd20, BOUND_EXACT), 0);
      send_beat(make_req(ACT_SEARCH, 64'd0, 8'd0, 2'd0), 0);
      send_beat(make_req(ACT_STORE, 64'hC00, 8'd5, 2'd0), 0);
      send_beat(make_req(ACT_PROBE, 64'h400, 8'd0, 2'd0), 0);
      send_beat(make_req(ACT_PROBE, 64'h800, 8'd0, 2'd0), 0);
      send_beat(make_req(ACT_PROBE, 64'hC00, 8'd0, 2'd0), 0);
      send_beat(make_req(ACT_NONE, '1, 8'd255, 2'd3), 0);
      r = '1;
      r.action = ACT_STORE;
      send_beat(r, 0);
      r.action = ACT_PROBE;
      send_beat(r, 0);
      // wrap the generation counter past 255
      for (int i = 0; i < 260; i++) begin
         if (i % 37 == 0) send_beat(make_req(ACT_STORE, key_pool[i % 16],
                                             8'($urandom), 2'($urandom)), 0);
         send_beat(make_req(ACT_SEARCH, {$urandom, $urandom}, 8'd0, 2'd0), 0);
      end
      send_beat(make_req(ACT_PROBE, '1, 8'd0, 2'd0), 0);

      // hold off until drained
      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);

      for (int i = 0; i < 965; i++) begin
         r = random_req();
         if (i % 2 == 0) r.key = 64'($urandom_range(3)) | 64'h1000;
         send_beat(r, !(i >= 400 && i < 600));
      end

      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
